// ===== src/depth_map_triangle_mesher_defines.svh =====
// Assertion macros shared by the mesher RTL.
// Needs a clk and an arst_n in the scope that uses them.
`ifndef DEPTH_MAP_TRIANGLE_MESHER_DEFINES_SVH
`define DEPTH_MAP_TRIANGLE_MESHER_DEFINES_SVH

// same-cycle implication
`define DMTM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DMTM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dmtm_pkg.sv =====
// Shared types and constants of the depth map triangle mesher.
// No dependencies.
package dmtm_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	localparam logic [CFG_IDX_W-1:0] REG_INV_FX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIM  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH = 3'd5;

	localparam logic [24:0] RST_INV_FX    = 25'd16777;
	localparam logic [24:0] RST_INV_FY    = 25'd16777;
	localparam logic [15:0] RST_CENTER_X  = 16'd5120;
	localparam logic [15:0] RST_CENTER_Y  = 16'd3840;
	localparam logic [20:0] RST_EDGE_LIM  = 21'd10486;
	localparam logic [12:0] RST_IMG_WIDTH = 13'd640;

	// ceil(2^39 / 510): exact floor divide by 510 for numerators below 2^30
	localparam logic [30:0] Z_RECIP = 31'd1077952577;
	localparam int          Z_SHIFT = 39;
	localparam logic [21:0] Z_MAX   = 22'd1048576;

	localparam logic [24:0] FACE_MAX = 25'h1FFFFFF;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 192;

	// output tdata field offsets
	localparam int OFS_POS_X  = 0;
	localparam int OFS_POS_Y  = 24;
	localparam int OFS_POS_Z  = 48;
	localparam int OFS_RED    = 69;
	localparam int OFS_GREEN  = 77;
	localparam int OFS_BLUE   = 85;
	localparam int OFS_CA     = 93;
	localparam int OFS_CB     = 117;
	localparam int OFS_CC     = 141;
	localparam int OFS_FACES  = 165;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_FACE   = 1'b1;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [20:0]        z;
	} vtx_t;

	localparam int VTX_W = $bits(vtx_t);

	typedef struct packed {
		logic tri_a;
		logic tri_b;
	} tri_ok_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZMUL,
		ST_ZSAT,
		ST_PMUL,
		ST_PRND,
		ST_DIST,
		ST_CMP,
		ST_WRITE,
		ST_VTX,
		ST_FACE1,
		ST_FACE2
	} state_t;

endpackage

// ===== src/dmtm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dmtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/dmtm_proj.sv =====
// Back-projection pipeline: mag * inv * z, scaled by 2^-28, rounded, saturated.
// Depends on dmtm_pkg.
module dmtm_proj import dmtm_pkg::*; #(
	parameter int MAGW = 16
) (
	input  logic               clk,
	input  logic [MAGW-1:0]    mag,
	input  logic               neg,
	input  logic [24:0]        inv,
	input  logic [20:0]        z,
	output logic signed [23:0] pos
);

	localparam int TW  = MAGW + 25;
	localparam int HW  = TW - 21;
	localparam int PW  = TW + 22;
	localparam int RW  = PW - 28;

	logic [TW-1:0]      t_s1;
	logic [41:0]        lo_s2;
	logic [HW+20:0]     hi_s2;
	logic [PW-1:0]      prod;
	logic [RW-1:0]      r;
	logic signed [23:0] pos_c;

	always_ff @(posedge clk) begin
		t_s1  <= TW'(mag) * TW'(inv);
		lo_s2 <= 42'(t_s1[20:0]) * 42'(z);
		hi_s2 <= (HW+21)'(t_s1[TW-1:21]) * (HW+21)'(z);
		pos   <= pos_c;
	end

	always_comb begin
		prod = {1'b0, hi_s2, 21'b0} + PW'(lo_s2) + PW'(64'd1 << 27);
		r    = prod[PW-1:28];
		if (neg) begin
			if (r >= RW'(64'd8388608)) begin
				pos_c = 24'sh800000;
			end else begin
				pos_c = -$signed({1'b0, r[22:0]});
			end
		end else begin
			if (r > RW'(64'd8388607)) begin
				pos_c = 24'sh7FFFFF;
			end else begin
				pos_c = $signed({1'b0, r[22:0]});
			end
		end
	end

endmodule

// ===== src/dmtm_edge.sv =====
// Edge-length test of the two quad triangles: squared distances, then compare.
// Depends on dmtm_pkg.
module dmtm_edge import dmtm_pkg::*; (
	input  logic    clk,
	input  vtx_t    upl,
	input  vtx_t    up,
	input  vtx_t    lft,
	input  vtx_t    cur,
	input  logic [20:0] limit,
	output tri_ok_t ok
);

	localparam int NE = 5;

	vtx_t        ea [NE];
	vtx_t        eb [NE];
	logic [49:0] sqx_s1 [NE];
	logic [49:0] sqy_s1 [NE];
	logic [43:0] sqz_s1 [NE];
	logic [41:0] lim_s1;
	logic [NE-1:0] short_c;

	// edges: upl-up, upl-left, up-left, up-cur, cur-left
	assign ea[0] = upl; assign eb[0] = up;
	assign ea[1] = upl; assign eb[1] = lft;
	assign ea[2] = up;  assign eb[2] = lft;
	assign ea[3] = up;  assign eb[3] = cur;
	assign ea[4] = cur; assign eb[4] = lft;

	for (genvar e = 0; e < NE; e++) begin : g_edge
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		logic signed [21:0] dz;
		logic [51:0]        sum;
		assign dx = 25'(ea[e].x) - 25'(eb[e].x);
		assign dy = 25'(ea[e].y) - 25'(eb[e].y);
		assign dz = $signed({1'b0, ea[e].z}) - $signed({1'b0, eb[e].z});
		always_ff @(posedge clk) begin
			sqx_s1[e] <= $unsigned(50'(dx) * 50'(dx));
			sqy_s1[e] <= $unsigned(50'(dy) * 50'(dy));
			sqz_s1[e] <= $unsigned(44'(dz) * 44'(dz));
		end
		assign sum = 52'(sqx_s1[e]) + 52'(sqy_s1[e]) + 52'(sqz_s1[e]);
		assign short_c[e] = sum < 52'(lim_s1);
	end

	always_ff @(posedge clk) begin
		lim_s1   <= 42'(limit) * 42'(limit);
		ok.tri_a <= short_c[0] & short_c[1] & short_c[2];
		ok.tri_b <= short_c[3] & short_c[2] & short_c[4];
	end

endmodule

// ===== src/depth_map_triangle_mesher.sv =====
// Depth map triangle mesher top level: sequencer, counters, row store, output register.
// Depends on dmtm_pkg, dmtm_ram, dmtm_proj, dmtm_edge and the assertion macro header.
//
// Usage:
//  s_* channel takes one depth pixel per transfer in raster order (tuser = frame start,
//  which clears column, row and face count). m_* channel gives per pixel one vertex
//  result, then up to two face results (tuser = kind, tlast on the final one).
//  Configuration registers are written through cfg_we/cfg_addr/cfg_wdata while idle.
//  After the input transfer a pixel passes ZMUL, ZSAT, PMUL, PRND, DIST, CMP, WRITE
//  and VTX, which loads the vertex into the output register; the faces follow one per
//  cycle while the receiver is ready. The next pixel is taken once the last result
//  sits in the output register. The sequence is set by the depth divide, the two-stage
//  back-projection multiplies, the edge-length squares and the single write port of
//  the row store, which takes the delayed write and, at row end, the current vertex.
//  Reset clears counters and the left vertex and sets the configuration defaults; the
//  row store is not cleared and needs no clearing pass. A stalled receiver holds the
//  result in the output register and the sequencer waits before the next result.
`include "depth_map_triangle_mesher_defines.svh"
module depth_map_triangle_mesher import dmtm_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // depth_value, red_in, green_in, blue_in
	input  logic                  s_tuser,  // frame_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // pos_x, pos_y, pos_z, red_out, green_out,
	                                        // blue_out, corner_a, corner_b, corner_c,
	                                        // face_total, zero fill
	output logic                  m_tuser,  // kind
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RH   = $clog2(MAX_HEIGHT);
	localparam int MAGW = ((CW > RH ? CW : RH) + 4 > 16) ? (CW > RH ? CW : RH) + 4 : 16;

	logic [24:0] inv_fx_q, inv_fy_q;
	logic [15:0] cx_q, cy_q;
	logic [20:0] lim_q;
	logic [12:0] img_w_q;

	state_t state_q, state_d;

	logic [CW-1:0] col_q, ccol_q, col_s;
	logic [RH-1:0] row_q, crow_q, row_s;
	logic [24:0]   fc_q, fc_next;
	logic [15:0]   d_q;
	logic [7:0]    red_q, grn_q, blu_q;
	logic [MAGW-1:0] magx_q, magy_q, p16x, p16y;
	logic          negx_q, negy_q;
	logic [60:0]   zprod_q;
	logic [29:0]   znum;
	logic [21:0]   zq;
	logic [20:0]   z_q;
	vtx_t          up_q, upl_q, left_q, vtx_q, cur_c;
	logic signed [23:0] posx, posy;
	logic [23:0]   idx_q, i1, i2, i4;
	tri_ok_t       ok_c, ok_q;
	logic [31:0]   w_eff;
	logic          row_end, face_en, out_free;

	logic                ram_we, ram_re;
	logic [CW-1:0]       ram_waddr;
	logic [VTX_W-1:0]    ram_wdata, ram_rdata;

	logic                  load_out;
	logic [OUT_DATA_W-1:0] out_data_c;
	logic                  out_kind_c, out_last_c;
	logic                  accept;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_fx_q <= RST_INV_FX;
			inv_fy_q <= RST_INV_FY;
			cx_q     <= RST_CENTER_X;
			cy_q     <= RST_CENTER_Y;
			lim_q    <= RST_EDGE_LIM;
			img_w_q  <= RST_IMG_WIDTH;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_INV_FX:    inv_fx_q <= cfg_wdata;
				REG_INV_FY:    inv_fy_q <= cfg_wdata;
				REG_CENTER_X:  cx_q     <= cfg_wdata[15:0];
				REG_CENTER_Y:  cy_q     <= cfg_wdata[15:0];
				REG_EDGE_LIM:  lim_q    <= cfg_wdata[20:0];
				REG_IMG_WIDTH: img_w_q  <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (img_w_q < 13'd2) begin
			w_eff = 32'd2;
		end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = 32'(img_w_q);
		end
	end

	assign accept  = s_tvalid && s_tready;
	assign col_s   = s_tuser ? '0 : col_q;
	assign row_s   = s_tuser ? '0 : row_q;
	assign p16x    = MAGW'({col_s, 4'b0});
	assign p16y    = MAGW'({row_s, 4'b0});
	assign znum    = 30'({d_q, 13'b0}) + 30'd255;
	assign zq      = zprod_q[60:Z_SHIFT];
	assign cur_c   = '{x: posx, y: posy, z: z_q};
	assign row_end = 32'(ccol_q) >= w_eff - 32'd1;
	assign face_en = (crow_q != '0) && (ccol_q != '0);
	assign fc_next = (fc_q == FACE_MAX) ? fc_q : fc_q + 25'd1;
	assign out_free = !m_tvalid || m_tready;
	assign i4 = idx_q - 24'd1;
	assign i2 = idx_q - 24'(w_eff);
	assign i1 = i2 - 24'd1;

	dmtm_ram #(.WIDTH(VTX_W), .DEPTH(MAX_WIDTH)) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ccol_q),
		.rdata (ram_rdata)
	);

	dmtm_proj #(.MAGW(MAGW)) u_proj_x (
		.clk (clk), .mag (magx_q), .neg (negx_q), .inv (inv_fx_q), .z (z_q), .pos (posx)
	);

	dmtm_proj #(.MAGW(MAGW)) u_proj_y (
		.clk (clk), .mag (magy_q), .neg (negy_q), .inv (inv_fy_q), .z (z_q), .pos (posy)
	);

	dmtm_edge u_edge (
		.clk (clk), .upl (upl_q), .up (up_q), .lft (left_q), .cur (cur_c),
		.limit (lim_q), .ok (ok_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = ccol_q;
		ram_wdata  = cur_c;
		load_out   = 1'b0;
		out_kind_c = KIND_VERTEX;
		out_last_c = 1'b1;
		out_data_c = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_ZMUL;
				end
			end
			ST_ZMUL: begin
				ram_re  = 1'b1;
				state_d = ST_ZSAT;
			end
			ST_ZSAT: state_d = ST_PMUL;
			ST_PMUL: state_d = ST_PRND;
			ST_PRND: state_d = ST_DIST;
			ST_DIST: state_d = ST_CMP;
			ST_CMP: begin
				ram_we    = ccol_q != '0;
				ram_waddr = ccol_q - CW'(1);
				ram_wdata = left_q;
				state_d   = ST_WRITE;
			end
			ST_WRITE: begin
				ram_we  = row_end;
				state_d = ST_VTX;
			end
			ST_VTX: begin
				out_data_c[OFS_POS_X +: 24] = vtx_q.x;
				out_data_c[OFS_POS_Y +: 24] = vtx_q.y;
				out_data_c[OFS_POS_Z +: 21] = vtx_q.z;
				out_data_c[OFS_RED   +: 8]  = red_q;
				out_data_c[OFS_GREEN +: 8]  = grn_q;
				out_data_c[OFS_BLUE  +: 8]  = blu_q;
				out_last_c = !(face_en && (ok_q.tri_a || ok_q.tri_b));
				if (out_free) begin
					load_out = 1'b1;
					if (face_en && ok_q.tri_a) begin
						state_d = ST_FACE1;
					end else if (face_en && ok_q.tri_b) begin
						state_d = ST_FACE2;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FACE1: begin
				out_kind_c = KIND_FACE;
				out_data_c[OFS_CA    +: 24] = i1;
				out_data_c[OFS_CB    +: 24] = i2;
				out_data_c[OFS_CC    +: 24] = i4;
				out_data_c[OFS_FACES +: 25] = fc_next;
				out_last_c = !ok_q.tri_b;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ok_q.tri_b ? ST_FACE2 : ST_IDLE;
				end
			end
			ST_FACE2: begin
				out_kind_c = KIND_FACE;
				out_data_c[OFS_CA    +: 24] = i2;
				out_data_c[OFS_CB    +: 24] = idx_q;
				out_data_c[OFS_CC    +: 24] = i4;
				out_data_c[OFS_FACES +: 25] = fc_next;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			fc_q     <= '0;
			left_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept && s_tuser) begin
				fc_q <= '0;
			end else if (load_out && out_kind_c == KIND_FACE) begin
				fc_q <= fc_next;
			end
			if (state_q == ST_WRITE) begin
				left_q <= cur_c;
				if (row_end) begin
					col_q <= '0;
					row_q <= (32'(crow_q) + 32'd1 >= 32'(MAX_HEIGHT)) ? '0 : crow_q + RH'(1);
				end else begin
					col_q <= ccol_q + CW'(1);
					row_q <= crow_q;
				end
			end
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ccol_q <= col_s;
			crow_q <= row_s;
			d_q    <= s_tdata[15:0];
			red_q  <= s_tdata[23:16];
			grn_q  <= s_tdata[31:24];
			blu_q  <= s_tdata[39:32];
			negx_q <= p16x < MAGW'(cx_q);
			magx_q <= (p16x < MAGW'(cx_q)) ? MAGW'(cx_q) - p16x : p16x - MAGW'(cx_q);
			negy_q <= p16y < MAGW'(cy_q);
			magy_q <= (p16y < MAGW'(cy_q)) ? MAGW'(cy_q) - p16y : p16y - MAGW'(cy_q);
		end
		if (state_q == ST_ZMUL) begin
			zprod_q <= znum * Z_RECIP;
		end
		if (state_q == ST_ZSAT) begin
			z_q  <= (zq > Z_MAX) ? Z_MAX[20:0] : zq[20:0];
			up_q <= ram_rdata;
		end
		if (state_q == ST_DIST) begin
			idx_q <= 24'(32'(crow_q) * w_eff + 32'(ccol_q));
		end
		if (state_q == ST_WRITE) begin
			ok_q  <= ok_c;
			upl_q <= up_q;
			vtx_q <= cur_c;
		end
		if (load_out) begin
			m_tdata <= out_data_c;
			m_tuser <= out_kind_c;
			m_tlast <= out_last_c;
		end
	end

	`DMTM_ASSERT_NXT(a_busy_after_accept, accept, !s_tready, "input taken while busy")
	`DMTM_ASSERT_IMP(a_ram_one_access, ram_we, !ram_re, "row store read and write collide")
	`DMTM_ASSERT_IMP(a_face_counted, m_tvalid && m_tuser == KIND_FACE,
		m_tdata[OFS_FACES +: 25] != '0, "face result with zero face count")
	`DMTM_ASSERT_IMP(a_face_needs_corner, load_out && out_kind_c == KIND_FACE,
		face_en, "face outside a quad corner")

endmodule
